// File: rtl/cdr_pkg.sv
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types, constants and byte tables of the captive DNS responder.
// ----------------------------------------------------------------------------
package cdr_pkg;

   localparam int ByteW   = 8;
   localparam int WordW   = 32;
   localparam int FieldW  = 6;   // label length up to 63
   localparam int LabelW  = 7;   // label count up to 127
   localparam int HdrLen  = 12;  // DNS header bytes
   localparam int AnsLen  = 16;  // appended A-record bytes
   localparam int AnsIdxW = 5;   // counts echo plus answer beats, 0..16

   localparam logic [ByteW-1:0] OpcodeMask = 8'hF8;  // QR and opcode bits
   localparam logic [ByteW-1:0] LabelTopMask = 8'hC0;
   localparam logic [ByteW-1:0] LabelMax = 8'd63;
   localparam logic [FieldW-1:0] QtailLen = 6'd4;    // QTYPE + QCLASS

   localparam logic [0:0] CsrAddress = 1'b0;
   localparam logic [0:0] CsrTtl     = 1'b1;

   localparam logic [WordW-1:0] AddressReset = 32'hC0A8_0401;
   localparam logic [WordW-1:0] TtlReset     = 32'd60;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LABEL_LEN,
      PH_LABEL_BODY,
      PH_QTAIL,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      PLAN_NONE,    // echo at most
      PLAN_ANSWER,  // echo at most, then the answer record
      PLAN_DROP     // single drop marker
   } plan_kind_type;

   typedef struct packed {
      logic                echo;
      logic [ByteW-1:0]    echo_byte;
      plan_kind_type       kind;
   } plan_type;

   // Rewritten header bytes 2..11: response, one question, one answer.
   function automatic logic [ByteW-1:0] header_byte(input logic [3:0] idx);
      logic [ByteW-1:0] b;
      unique case (idx)
         4'd0:    b = 8'h81;
         4'd1:    b = 8'h80;
         4'd3:    b = 8'h01;
         4'd5:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // A-record answer: name pointer, type, class, TTL, length, address.
   function automatic logic [ByteW-1:0] answer_byte(input logic [3:0] idx,
                                                    input logic [WordW-1:0] ttl,
                                                    input logic [WordW-1:0] addr);
      logic [ByteW-1:0] b;
      unique case (idx)
         4'd0:    b = 8'hC0;
         4'd1:    b = 8'h0C;
         4'd3:    b = 8'h01;
         4'd5:    b = 8'h01;
         4'd6:    b = ttl[31:24];
         4'd7:    b = ttl[23:16];
         4'd8:    b = ttl[15:8];
         4'd9:    b = ttl[7:0];
         4'd11:   b = 8'h04;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         4'd15:   b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/cdr_parser.sv
// ----------------------------------------------------------------------------
// cdr_parser
// Per-byte query parse: header checks, name labels, QTYPE/QCLASS, length.
// ----------------------------------------------------------------------------
module cdr_parser #(
   parameter int MAX_PACKET = 512,
   parameter int MAX_LABELS = 127
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [cdr_pkg::ByteW-1:0] in_byte,
   input  logic                    in_last,
   output cdr_pkg::plan_type       plan
);

   localparam int PosW = $clog2(MAX_PACKET + 1);
   localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET);
   localparam logic [PosW-1:0] AnsLimit = PosW'(MAX_PACKET - cdr_pkg::AnsLen - 1);
   localparam logic [cdr_pkg::LabelW-1:0] MaxLab = cdr_pkg::LabelW'(MAX_LABELS);

   logic [PosW-1:0]            pos_ff, pos_in;
   cdr_pkg::phase_type         phase_ff, phase_in;
   logic [cdr_pkg::FieldW-1:0] left_ff, left_in;
   logic [cdr_pkg::LabelW-1:0] labels_ff, labels_in;
   logic                       rej_ff, rej_in;

   logic                       echo;
   logic [cdr_pkg::ByteW-1:0]  echo_byte;
   logic [cdr_pkg::FieldW-1:0] left_dec;

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      labels_in = labels_ff;
      rej_in    = rej_ff;
      echo      = 1'b0;
      echo_byte = in_byte;
      left_dec  = left_ff;

      if (!rej_ff && pos_ff >= MaxPos) begin
         rej_in = 1'b1;
      end

      if (!rej_in) begin
         unique case (phase_ff)
            cdr_pkg::PH_HEADER: begin
               if (pos_ff == PosW'(2) && (in_byte & cdr_pkg::OpcodeMask) != '0) begin
                  rej_in = 1'b1;
               end else if (pos_ff == PosW'(4) && in_byte != 8'd0) begin
                  rej_in = 1'b1;
               end else if (pos_ff == PosW'(5) && in_byte != 8'd1) begin
                  rej_in = 1'b1;
               end else begin
                  echo = 1'b1;
                  if (pos_ff >= PosW'(2) && pos_ff < PosW'(cdr_pkg::HdrLen)) begin
                     echo_byte = cdr_pkg::header_byte(pos_ff[3:0] - 4'd2);
                  end
                  if (pos_ff >= PosW'(cdr_pkg::HdrLen - 1)) begin
                     phase_in = cdr_pkg::PH_LABEL_LEN;
                  end
               end
            end
            cdr_pkg::PH_LABEL_LEN: begin
               if (in_byte == 8'd0) begin
                  phase_in = cdr_pkg::PH_QTAIL;
                  left_in  = cdr_pkg::QtailLen;
                  echo     = 1'b1;
               end else if ((in_byte & cdr_pkg::LabelTopMask) != '0 ||
                            in_byte > cdr_pkg::LabelMax || labels_ff >= MaxLab) begin
                  rej_in = 1'b1;
               end else begin
                  labels_in = labels_ff + 1'b1;
                  left_in   = in_byte[cdr_pkg::FieldW-1:0];
                  phase_in  = cdr_pkg::PH_LABEL_BODY;
                  echo      = 1'b1;
               end
            end
            cdr_pkg::PH_LABEL_BODY: begin
               echo = 1'b1;
               if (left_ff != '0) begin
                  left_dec = left_ff - 1'b1;
               end
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = cdr_pkg::PH_LABEL_LEN;
               end
            end
            cdr_pkg::PH_QTAIL: begin
               // expected bytes 00 01 00 01: low byte of each field is 1
               if (left_ff == '0 || left_ff > cdr_pkg::QtailLen ||
                   in_byte != {7'd0, left_ff[0]}) begin
                  rej_in = 1'b1;
               end else begin
                  echo     = 1'b1;
                  left_dec = left_ff - 1'b1;
                  left_in  = left_dec;
                  if (left_dec == '0) begin
                     if (pos_ff > AnsLimit) begin
                        rej_in = 1'b1;
                        echo   = 1'b0;
                     end else begin
                        phase_in = cdr_pkg::PH_TRAIL;
                     end
                  end
               end
            end
            cdr_pkg::PH_TRAIL: begin
            end
            default: begin
               rej_in = 1'b1;
            end
         endcase
      end

      pos_in = (pos_ff < MaxPos) ? pos_ff + 1'b1 : pos_ff;

      plan.echo_byte = echo_byte;
      if (!in_last) begin
         plan.echo = echo && !rej_in;
         plan.kind = cdr_pkg::PLAN_NONE;
      end else if (rej_in || phase_in != cdr_pkg::PH_TRAIL) begin
         plan.echo = 1'b0;
         plan.kind = cdr_pkg::PLAN_DROP;
      end else begin
         plan.echo = echo;
         plan.kind = cdr_pkg::PLAN_ANSWER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= cdr_pkg::PH_HEADER;
         left_ff   <= '0;
         labels_ff <= '0;
         rej_ff    <= 1'b0;
      end else if (fire) begin
         if (in_last) begin
            pos_ff    <= '0;
            phase_ff  <= cdr_pkg::PH_HEADER;
            left_ff   <= '0;
            labels_ff <= '0;
            rej_ff    <= 1'b0;
         end else begin
            pos_ff    <= pos_in;
            phase_ff  <= phase_in;
            left_ff   <= left_in;
            labels_ff <= labels_in;
            rej_ff    <= rej_in;
         end
      end
   end

endmodule

// File: rtl/cdr_emitter.sv
// ----------------------------------------------------------------------------
// cdr_emitter
// Two-entry plan queue and response sequencer: echo, answer or drop beats.
// ----------------------------------------------------------------------------
module cdr_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cdr_pkg::plan_type         plan,
   output logic                      full,
   input  logic [cdr_pkg::WordW-1:0] ttl,
   input  logic [cdr_pkg::WordW-1:0] addr,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [cdr_pkg::ByteW-1:0] rsp_out_byte,
   output logic                      rsp_out_last,
   output logic                      rsp_out_drop
);

   cdr_pkg::plan_type                 plan_ff [2];
   logic                              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                        count_ff, count_in;
   logic [cdr_pkg::AnsIdxW-1:0]       idx_ff, idx_in;

   cdr_pkg::plan_type                 head;
   logic                              head_valid;
   logic                              has_beat;
   logic                              final_beat;
   logic                              pop;
   logic [cdr_pkg::AnsIdxW-1:0]       ans_idx;

   assign full       = (count_ff == 2'd2);
   assign head       = plan_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);

   always_comb begin
      ans_idx      = idx_ff - cdr_pkg::AnsIdxW'(head.echo);
      has_beat     = 1'b1;
      final_beat   = 1'b1;
      rsp_out_byte = head.echo_byte;
      rsp_out_last = 1'b0;
      rsp_out_drop = 1'b0;
      case (head.kind)
         cdr_pkg::PLAN_DROP: begin
            rsp_out_byte = '0;
            rsp_out_last = 1'b1;
            rsp_out_drop = 1'b1;
         end
         cdr_pkg::PLAN_ANSWER: begin
            if (!(head.echo && idx_ff == '0)) begin
               rsp_out_byte = cdr_pkg::answer_byte(ans_idx[3:0], ttl, addr);
               rsp_out_last = (ans_idx == cdr_pkg::AnsIdxW'(cdr_pkg::AnsLen - 1));
            end
            final_beat = rsp_out_last;
         end
         default: begin
            has_beat = head.echo;
         end
      endcase
      rsp_valid = head_valid && has_beat;
      pop       = head_valid && (!has_beat || (rsp_ready && final_beat));
      idx_in    = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (rsp_valid && rsp_ready) begin
         idx_in = idx_ff + 1'b1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         plan_ff[wr_ptr_ff] <= plan;
      end
   end

endmodule

// File: rtl/captive_dns_responder_core.sv
// ----------------------------------------------------------------------------
// captive_dns_responder_core
// Streaming captive-portal DNS responder: validates an A query byte by byte,
// echoes it with a rewritten header and appends a fixed A-record answer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one query byte per beat, req_in_last on the final byte.
//  - rsp_ channel: response bytes, cut-through. rsp_out_last marks the last
//    beat of a packet; rsp_out_drop on that beat tells the consumer to throw
//    away every byte already sent for the packet (the beat's byte is zero).
//  - csr_ port: index 0 answer address, index 1 TTL; write only while idle.
// Echo path: a byte's plan is registered in the plan queue before its echo shows on rsp.
// Throughput: one byte per cycle while req_ready is high. The final byte of
//   a good query expands to up to 17 beats (echo plus the 16-byte answer); the
//   two-entry plan queue between parser and output sequencer then fills and
//   holds req_ready low until the answer drains.
// Stall: with rsp_ready low, one more byte is still taken into the queue;
//   req_ready is a pure register decode, no path from rsp_ready.
// Reset: synchronous; parse state to header phase, queue empty, CSRs to
//   192.168.4.1 and a TTL of 60 seconds.
// ----------------------------------------------------------------------------
module captive_dns_responder_core #(
   parameter int MAX_PACKET = 512,
   parameter int MAX_LABELS = 127
) (
   input  logic                      clock,
   input  logic                      reset,
   // query bytes
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [cdr_pkg::ByteW-1:0] req_in_byte,
   input  logic                      req_in_last,
   // response bytes
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [cdr_pkg::ByteW-1:0] rsp_out_byte,
   output logic                      rsp_out_last,
   output logic                      rsp_out_drop,
   // configuration writes
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [cdr_pkg::WordW-1:0] csr_wdata
);

   logic                      req_fire;
   logic                      queue_full;
   cdr_pkg::plan_type         plan;
   logic [cdr_pkg::WordW-1:0] addr_ff;
   logic [cdr_pkg::WordW-1:0] ttl_ff;

   assign req_ready = !queue_full;
   assign req_fire  = req_valid && req_ready;

   // Answer registers, read live by the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= cdr_pkg::AddressReset;
         ttl_ff  <= cdr_pkg::TtlReset;
      end else if (csr_we) begin
         unique case (csr_index)
            cdr_pkg::CsrAddress: addr_ff <= csr_wdata;
            cdr_pkg::CsrTtl:     ttl_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Parse each accepted beat into a plan: echo byte, answer or drop.
   cdr_parser #(
      .MAX_PACKET (MAX_PACKET),
      .MAX_LABELS (MAX_LABELS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .plan    (plan)
   );

   // Queue plans and expand them into response beats.
   cdr_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .push         (req_fire),
      .plan         (plan),
      .full         (queue_full),
      .ttl          (ttl_ff),
      .addr         (addr_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_out_drop (rsp_out_drop)
   );

endmodule
